// ----- sv/polyphase_fir_decimator_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef POLYPHASE_FIR_DECIMATOR_CORE_ASSERT_SVH
`define POLYPHASE_FIR_DECIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, quiet while dis is high.
`define PFD_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("pfd assertion failed");

// Next-cycle implication, quiet while dis is high.
`define PFD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("pfd assertion failed");

`endif

// ----- sv/pfd_pkg.sv -----
`timescale 1ns / 1ps

package pfd_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 8;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 24;
  localparam int SUM_W     = 26;
  localparam int ACC_W     = 32;
  localparam int OUT_SHIFT = 14;

  // Coefficient register file: one packed row of three taps per phase
  localparam int COEF_REGS = 3;
  localparam int ROW_TAPS  = 3;
  localparam int REG_W     = COEF_W * ROW_TAPS;
  localparam int INDEX_W   = 2;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_COEF_PHASE0 = 2'd0;
  localparam logic [INDEX_W-1:0] REG_COEF_PHASE1 = 2'd1;
  localparam logic [INDEX_W-1:0] REG_COEF_PHASE2 = 2'd2;

  localparam logic [REG_W-1:0] COEF_PHASE0_RST = 48'd270075142;
  localparam logic [REG_W-1:0] COEF_PHASE1_RST = 48'd5523598016512;
  localparam logic [REG_W-1:0] COEF_PHASE2_RST = 48'd281067332304801;

  // Phase counter
  localparam int PHASE_W = 2;
  localparam int PHASES  = 3;
  localparam logic [PHASE_W-1:0] PHASE_RST  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_EMIT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASES - 1);

  // Default number of tap lanes
  localparam int TAP_COUNT_DEF = 3;

endpackage

// ----- sv/polyphase_fir_decimator_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload          Word
// input     in_valid / in_stall    sample_in [7:0]  one signed sample
// output    out_valid / out_stall  sample_out [7:0] one decimated sample
// config    cfg_write              cfg_index, cfg_data [47:0]
//
// One sample is taken every cycle unless in_stall is high; a result word
// follows every third sample, registered as its last sample is taken.
// Lane multiplies, the adder chain and the accumulator are each one register
// stage per sample, so the whole datapath advances once per accepted word.
// Reset (rst, synchronous) zeroes the lanes, skew lines and accumulator,
// loads the default coefficients and sets the phase to two.
// in_stall rises only while a result waits in the output register and
// out_stall holds it there; no input is dropped.
module polyphase_fir_decimator_core #(
  parameter int TAP_COUNT = pfd_pkg::TAP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pfd_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pfd_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                cfg_write,
  input  logic [pfd_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [pfd_pkg::REG_W-1:0]           cfg_data
);

  localparam int SW         = pfd_pkg::SAMPLE_W;
  localparam int CW         = pfd_pkg::COEF_W;
  localparam int PW         = pfd_pkg::PROD_W;
  localparam int SUMW       = pfd_pkg::SUM_W;
  localparam int AW         = pfd_pkg::ACC_W;
  localparam int SKEW_DEPTH = TAP_COUNT + 1;

  logic [pfd_pkg::REG_W-1:0]   coef [pfd_pkg::COEF_REGS];
  logic [pfd_pkg::REG_W-1:0]   coef_row;
  logic [SW-1:0]               lane_input [TAP_COUNT];
  logic [SW-1:0]               lane_input_next [TAP_COUNT];
  logic [PW-1:0]               lane_product [TAP_COUNT];
  logic [PW-1:0]               lane_product_next [TAP_COUNT];
  logic [SUMW-1:0]             lane_sum [TAP_COUNT];
  logic [SUMW-1:0]             lane_sum_next [TAP_COUNT];
  logic [SW-1:0]               skew_delay [TAP_COUNT-1][SKEW_DEPTH];
  logic [AW-1:0]               decim_accumulator;
  logic [AW-1:0]               chain_out;
  logic [pfd_pkg::PHASE_W-1:0] phase_index;
  logic [pfd_pkg::PHASE_W-1:0] phase_index_next;
  logic                        in_take;
  logic                        emit;

  // Accept while the output register is empty or being drained
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign emit     = (phase_index == pfd_pkg::PHASE_EMIT);

  // Pick the coefficient row of the current phase; missing rows are zero
  always_comb begin
    if (phase_index < pfd_pkg::PHASE_W'(pfd_pkg::COEF_REGS)) begin
      coef_row = coef[phase_index];
    end else begin
      coef_row = '0;
    end
  end

  // Per-lane multiply and adder chain
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_lane
    logic [CW-1:0] tap_coef;
    logic [PW-1:0] lane_ext;
    logic [PW-1:0] coef_ext;

    if (i < pfd_pkg::ROW_TAPS) begin : g_coef
      assign tap_coef = coef_row[CW*i +: CW];
    end else begin : g_nocoef
      assign tap_coef = '0;
    end

    // Sign-extend both operands to the product width; the low bits match
    assign lane_ext = {{(PW-SW){lane_input[i][SW-1]}}, lane_input[i]};
    assign coef_ext = {{(PW-CW){tap_coef[CW-1]}}, tap_coef};
    assign lane_product_next[i] = PW'(lane_ext * coef_ext);

    if (i == 0) begin : g_first
      assign lane_input_next[i] = sample_in;
      assign lane_sum_next[i]   = {{(SUMW-PW){lane_product[i][PW-1]}}, lane_product[i]};
    end else begin : g_rest
      assign lane_input_next[i] = skew_delay[i-1][SKEW_DEPTH-1];
      assign lane_sum_next[i]   = {{(SUMW-PW){lane_product[i][PW-1]}}, lane_product[i]}
                                  + lane_sum[i-1];
    end
  end

  assign chain_out = {{(AW-SUMW){lane_sum[TAP_COUNT-1][SUMW-1]}}, lane_sum[TAP_COUNT-1]};

  // Rotate the phase
  always_comb begin
    if (phase_index >= pfd_pkg::PHASE_LAST) begin
      phase_index_next = '0;
    end else begin
      phase_index_next = phase_index + 1'b1;
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= pfd_pkg::COEF_PHASE0_RST;
      coef[1] <= pfd_pkg::COEF_PHASE1_RST;
      coef[2] <= pfd_pkg::COEF_PHASE2_RST;
    end else if (cfg_write) begin
      if (cfg_index == pfd_pkg::REG_COEF_PHASE0) begin
        coef[0] <= cfg_data;
      end
      if (cfg_index == pfd_pkg::REG_COEF_PHASE1) begin
        coef[1] <= cfg_data;
      end
      if (cfg_index == pfd_pkg::REG_COEF_PHASE2) begin
        coef[2] <= cfg_data;
      end
    end
  end

  // Advance lanes, skew lines, accumulator and phase on each taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        lane_input[i]   <= '0;
        lane_product[i] <= '0;
        lane_sum[i]     <= '0;
      end
      for (int i = 0; i < TAP_COUNT - 1; i++) begin
        for (int j = 0; j < SKEW_DEPTH; j++) begin
          skew_delay[i][j] <= '0;
        end
      end
      decim_accumulator <= '0;
      phase_index       <= pfd_pkg::PHASE_RST;
    end else if (in_take) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        lane_input[i]   <= lane_input_next[i];
        lane_product[i] <= lane_product_next[i];
        lane_sum[i]     <= lane_sum_next[i];
      end
      for (int i = 0; i < TAP_COUNT - 1; i++) begin
        skew_delay[i][0] <= lane_input_next[i];
        for (int j = 1; j < SKEW_DEPTH; j++) begin
          skew_delay[i][j] <= skew_delay[i][j-1];
        end
      end
      if (emit) begin
        decim_accumulator <= chain_out;
      end else begin
        decim_accumulator <= decim_accumulator + chain_out;
      end
      phase_index <= phase_index_next;
    end
  end

  // Output register: load on an emitting word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      sample_out <= decim_accumulator[pfd_pkg::OUT_SHIFT +: SW];
    end
  end

endmodule

// ----- sv/pfd_chk.sv -----
`timescale 1ns / 1ps
`include "polyphase_fir_decimator_core_assert.svh"

module pfd_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [pfd_pkg::SAMPLE_W-1:0] sample_in,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [pfd_pkg::SAMPLE_W-1:0] sample_out
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  // A stalled input word holds
  `PFD_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(sample_in))

  // A stalled result word holds
  `PFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sample_out))

  // Input backs up only behind a waiting result
  `PFD_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // A new result word comes only from a taken input word
  `PFD_ASSERT_NOW(a_out_source, clk, rst, $rose(out_valid), $past(in_take))

  // Reset empties the output register
  `PFD_ASSERT_NEXT(a_out_reset, clk, 1'b0, rst, !out_valid)

endmodule

bind polyphase_fir_decimator_core pfd_chk u_pfd_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out)
);
